[rtl/core/glzw_pkg.sv]
package glzw_pkg;

    localparam int MAX_CODES_DEF       = 4096;
    localparam int STACK_DEPTH_DEF     = 4096;
    localparam int BIT_BUFFER_BITS_DEF = 32;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_PUSH  = 2'd1;
    localparam logic [1:0] CMD_PULL  = 2'd2;

    localparam logic [2:0] ST_PIXEL   = 3'd0;
    localparam logic [2:0] ST_TAKEN   = 3'd1;
    localparam logic [2:0] ST_REFUSED = 3'd2;
    localparam logic [2:0] ST_NEED    = 3'd3;
    localparam logic [2:0] ST_END     = 3'd4;
    localparam logic [2:0] ST_EXHAUST = 3'd5;
    localparam logic [2:0] ST_CORRUPT = 3'd6;
    localparam logic [2:0] ST_STARTED = 3'd7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP,
        S_POP_WAIT,
        S_DECODE,
        S_WALK_RD,
        S_WALK,
        S_FINISH,
        S_SEND
    } glzw_state_t;

    typedef struct packed {
        logic start;
        logic push;
        logic pop_rd;
        logic pop_take;
        logic decode;
        logic walk_rd;
        logic walk;
        logic finish;
    } glzw_cmd_t;

    typedef struct packed {
        logic       stack_empty;
        logic       decode_done;
        logic       decode_walk;
        logic       walk_done;
        logic       walk_err;
        logic [2:0] status;
        logic [7:0] pixel;
    } glzw_stat_t;

endpackage

[rtl/core/glzw_ctrl.sv]
module glzw_ctrl
    import glzw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    output logic        out_valid,
    input  logic        out_ready,
    output glzw_cmd_t   cmd,
    input  glzw_stat_t  stat
);

    glzw_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (command)
                        CMD_START: begin cmd.start = 1'b1; state_next = S_SEND; end
                        CMD_PUSH:  begin cmd.push  = 1'b1; state_next = S_SEND; end
                        CMD_PULL:  state_next = S_POP;
                        default:   begin cmd.push  = 1'b1; state_next = S_SEND; end
                    endcase
                end
            end
            S_POP:
            begin
                if (stat.stack_empty)
                begin
                    state_next = S_DECODE;
                end
                else
                begin
                    cmd.pop_rd = 1'b1;
                    state_next = S_POP_WAIT;
                end
            end
            S_POP_WAIT:
            begin
                cmd.pop_take = 1'b1;
                state_next   = S_SEND;
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                if (stat.decode_done)
                begin
                    state_next = S_SEND;
                end
                else if (stat.decode_walk)
                begin
                    state_next = S_WALK_RD;
                end
            end
            S_WALK_RD:
            begin
                cmd.walk_rd = 1'b1;
                state_next  = S_WALK;
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (stat.walk_err)
                begin
                    state_next = S_SEND;
                end
                else if (stat.walk_done)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_WALK_RD;
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_POP_WAIT;
            end
            S_SEND:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

[rtl/core/glzw_dpath.sv]
module glzw_dpath
    import glzw_pkg::*;
#(
    parameter int MAX_CODES       = MAX_CODES_DEF,
    parameter int STACK_DEPTH     = STACK_DEPTH_DEF,
    parameter int BIT_BUFFER_BITS = BIT_BUFFER_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  command,
    input  logic [7:0]  data_byte,
    input  logic [3:0]  min_code_size,
    input  glzw_cmd_t   cmd,
    output glzw_stat_t  stat
);

    localparam int CW = $clog2(MAX_CODES);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int BW = $clog2(BIT_BUFFER_BITS + 1);

    logic [CW-1:0] prefix_mem [MAX_CODES];
    logic [7:0]    suffix_mem [MAX_CODES];
    logic [7:0]    stack_mem  [STACK_DEPTH];

    logic [SW:0]   stack_count_reg, stack_count_next;
    logic [BIT_BUFFER_BITS-1:0] buf_reg, buf_next;
    logic [BW-1:0] held_reg, held_next;
    logic [3:0]    cwid_reg, cwid_next;
    logic [3:0]    base_reg, base_next;
    logic [CW:0]   nfree_reg, nfree_next;
    logic [CW:0]   limit_reg, limit_next;
    logic [7:0]    first_reg, first_next;
    logic [CW-1:0] prev_reg, prev_next;
    logic          await_reg, await_next;
    logic [7:0]    left_reg, left_next;
    logic          ended_reg, ended_next;
    logic [CW:0]   walk_reg, walk_next;
    logic [CW-1:0] incode_reg, incode_next;
    logic [2:0]    status_reg, status_next;
    logic [7:0]    pixel_reg, pixel_next;

    logic [CW-1:0] rd_pfx;
    logic [7:0]    rd_sfx;
    logic [7:0]    rd_stk;

    logic          stk_we;
    logic [SW-1:0] stk_wa;
    logic [7:0]    stk_wd;
    logic          dict_we;
    logic [SW-1:0] stk_ra;
    logic [CW-1:0] walk_ra;

    logic [12:0]   clear_c;
    logic [12:0]   code;
    logic [12:0]   mask;
    logic [3:0]    size_c;

    assign clear_c = 13'd1 << base_reg;
    assign mask    = (13'd1 << cwid_reg) - 13'd1;
    assign code    = 13'(buf_reg) & mask;

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_wa] <= stk_wd;
        end
        if (dict_we)
        begin
            prefix_mem[nfree_reg[CW-1:0]] <= prev_reg;
            suffix_mem[nfree_reg[CW-1:0]] <= first_reg;
        end
        rd_stk <= stack_mem[stk_ra];
        rd_pfx <= prefix_mem[walk_ra];
        rd_sfx <= suffix_mem[walk_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_count_reg <= '0;
            buf_reg         <= '0;
            held_reg        <= '0;
            cwid_reg        <= 4'd9;
            base_reg        <= 4'd8;
            nfree_reg       <= (CW+1)'(258);
            limit_reg       <= (CW+1)'(512);
            first_reg       <= '0;
            prev_reg        <= '0;
            await_reg       <= 1'b1;
            left_reg        <= '0;
            ended_reg       <= 1'b0;
            walk_reg        <= '0;
            incode_reg      <= '0;
            status_reg      <= '0;
            pixel_reg       <= '0;
        end
        else
        begin
            stack_count_reg <= stack_count_next;
            buf_reg         <= buf_next;
            held_reg        <= held_next;
            cwid_reg        <= cwid_next;
            base_reg        <= base_next;
            nfree_reg       <= nfree_next;
            limit_reg       <= limit_next;
            first_reg       <= first_next;
            prev_reg        <= prev_next;
            await_reg       <= await_next;
            left_reg        <= left_next;
            ended_reg       <= ended_next;
            walk_reg        <= walk_next;
            incode_reg      <= incode_next;
            status_reg      <= status_next;
            pixel_reg       <= pixel_next;
        end
    end

    always_comb
    begin
        stack_count_next = stack_count_reg;
        buf_next   = buf_reg;
        held_next  = held_reg;
        cwid_next  = cwid_reg;
        base_next  = base_reg;
        nfree_next = nfree_reg;
        limit_next = limit_reg;
        first_next = first_reg;
        prev_next  = prev_reg;
        await_next = await_reg;
        left_next  = left_reg;
        ended_next = ended_reg;
        walk_next  = walk_reg;
        incode_next = incode_reg;
        status_next = status_reg;
        pixel_next  = pixel_reg;
        stk_we  = 1'b0;
        stk_wa  = stack_count_reg[SW-1:0];
        stk_wd  = '0;
        dict_we = 1'b0;
        stk_ra  = SW'(stack_count_reg - 1'b1);
        walk_ra = walk_reg[CW-1:0];
        size_c  = min_code_size;
        stat    = '0;
        stat.stack_empty = (stack_count_reg == '0);
        stat.status = status_reg;
        stat.pixel  = pixel_reg;

        if (cmd.start)
        begin
            if (size_c < 4'd2)
            begin
                size_c = 4'd2;
            end
            if (size_c > 4'd8)
            begin
                size_c = 4'd8;
            end
            base_next  = size_c;
            cwid_next  = size_c + 4'd1;
            nfree_next = (CW+1)'((13'd1 << size_c) + 13'd2);
            limit_next = (CW+1)'(13'd2 << size_c);
            await_next = 1'b1;
            stack_count_next = '0;
            buf_next   = '0;
            held_next  = '0;
            first_next = '0;
            prev_next  = '0;
            left_next  = '0;
            ended_next = 1'b0;
            status_next = ST_STARTED;
            pixel_next  = '0;
        end

        if (cmd.push)
        begin
            pixel_next  = '0;
            status_next = ST_TAKEN;
            if (command != CMD_PUSH)
            begin
                status_next = ST_REFUSED;
            end
            else if (ended_reg)
            begin
                status_next = ST_TAKEN;
            end
            else if (left_reg == '0)
            begin
                if (data_byte == '0)
                begin
                    ended_next = 1'b1;
                end
                else
                begin
                    left_next = data_byte;
                end
            end
            else if (32'(held_reg) + 32'd8 > 32'(BIT_BUFFER_BITS))
            begin
                status_next = ST_REFUSED;
            end
            else
            begin
                buf_next  = buf_reg | (BIT_BUFFER_BITS'(data_byte) << held_reg);
                held_next = held_reg + BW'(8);
                left_next = left_reg - 8'd1;
            end
        end

        if (cmd.pop_rd)
        begin
            stack_count_next = stack_count_reg - 1'b1;
        end

        if (cmd.pop_take)
        begin
            status_next = ST_PIXEL;
            pixel_next  = rd_stk;
        end

        if (cmd.decode)
        begin
            pixel_next = '0;
            if (32'(held_reg) < 32'(cwid_reg))
            begin
                stat.decode_done = 1'b1;
                status_next = ended_reg ? ST_EXHAUST : ST_NEED;
            end
            else if (code == clear_c + 13'd1)
            begin
                stat.decode_done = 1'b1;
                status_next = ST_END;
            end
            else
            begin
                buf_next  = buf_reg >> cwid_reg;
                held_next = held_reg - BW'(cwid_reg);
                if (code == clear_c)
                begin
                    cwid_next  = base_reg + 4'd1;
                    nfree_next = (CW+1)'(clear_c + 13'd2);
                    limit_next = (CW+1)'({clear_c[11:0], 1'b0});
                    await_next = 1'b1;
                    stack_count_next = '0;
                end
                else if (await_reg)
                begin
                    stat.decode_done = 1'b1;
                    if (code >= clear_c)
                    begin
                        status_next = ST_CORRUPT;
                    end
                    else
                    begin
                        await_next  = 1'b0;
                        first_next  = code[7:0];
                        prev_next   = CW'(code);
                        status_next = ST_PIXEL;
                        pixel_next  = code[7:0];
                    end
                end
                else if (code > 13'(nfree_reg))
                begin
                    stat.decode_done = 1'b1;
                    status_next = ST_CORRUPT;
                end
                else
                begin
                    stat.decode_walk = 1'b1;
                    incode_next = CW'(code);
                    walk_next   = (CW+1)'(code);
                    stack_count_next = '0;
                    if (code == 13'(nfree_reg))
                    begin
                        stk_we = 1'b1;
                        stk_wa = '0;
                        stk_wd = first_reg;
                        stack_count_next = (SW+1)'(1);
                        walk_next = (CW+1)'(prev_reg);
                    end
                end
            end
        end

        if (cmd.walk)
        begin
            if (13'(walk_reg) < clear_c)
            begin
                stat.walk_done = 1'b1;
                first_next = walk_reg[7:0];
                if (32'(stack_count_reg) >= 32'(STACK_DEPTH))
                begin
                    stat.walk_err = 1'b1;
                    stack_count_next = '0;
                    status_next = ST_CORRUPT;
                    pixel_next  = '0;
                end
                else
                begin
                    stk_we = 1'b1;
                    stk_wd = walk_reg[7:0];
                    stack_count_next = stack_count_reg + 1'b1;
                end
            end
            else if (32'(walk_reg) >= 32'(MAX_CODES) ||
                     (CW+1)'(rd_pfx) == walk_reg ||
                     32'(stack_count_reg) >= 32'(STACK_DEPTH))
            begin
                stat.walk_err = 1'b1;
                stack_count_next = '0;
                status_next = ST_CORRUPT;
                pixel_next  = '0;
            end
            else
            begin
                stk_we = 1'b1;
                stk_wd = rd_sfx;
                stack_count_next = stack_count_reg + 1'b1;
                walk_next = (CW+1)'(rd_pfx);
            end
        end

        if (cmd.finish)
        begin
            if (32'(nfree_reg) < 32'(MAX_CODES))
            begin
                dict_we    = 1'b1;
                nfree_next = nfree_reg + 1'b1;
                if (nfree_next >= limit_reg && 32'(limit_reg) < 32'(MAX_CODES))
                begin
                    limit_next = limit_reg << 1;
                    cwid_next  = cwid_reg + 4'd1;
                end
            end
            prev_next = incode_reg;
            stack_count_next = stack_count_reg - 1'b1;
        end
    end

endmodule

[rtl/core/gif_lzw_stream_decoder.sv]
// Channel  Handshake               Payload
// in       in_valid / in_ready     command, data_byte, min_code_size
// out      out_valid / out_ready   status, pixel
//
// One item in flight; start and push go from idle to send. A stack
// pixel takes pop, pop-wait; a literal, end, need-data or corrupt code
// takes pop, decode; a chained code adds a table read and a walk state
// per step, root included, then finish and pop-wait; clears re-decode.
// rst_n clears control state; tables hold no reset and need no sweep.
// in_ready is low from acceptance until the result beat leaves.
module gif_lzw_stream_decoder
    import glzw_pkg::*;
#(
    parameter int MAX_CODES       = MAX_CODES_DEF,
    parameter int STACK_DEPTH     = STACK_DEPTH_DEF,
    parameter int BIT_BUFFER_BITS = BIT_BUFFER_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] command,
    input  logic [7:0] data_byte,
    input  logic [3:0] min_code_size,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] status,
    output logic [7:0] pixel
);

    glzw_cmd_t  cmd;
    glzw_stat_t stat;

    glzw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    glzw_dpath #(
        .MAX_CODES       (MAX_CODES),
        .STACK_DEPTH     (STACK_DEPTH),
        .BIT_BUFFER_BITS (BIT_BUFFER_BITS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .command       (command),
        .data_byte     (data_byte),
        .min_code_size (min_code_size),
        .cmd           (cmd),
        .stat          (stat)
    );

    assign status = stat.status;
    assign pixel  = stat.pixel;

endmodule
